// ===== sv/wpr_pkg.sv =====
// Shared widths, register indexes and the per-channel result type of the
// wavelet plane recombiner. No dependencies.
package wpr_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 32;
    localparam int PROD_W    = SAMPLE_W + GAIN_W;
    localparam int ACC_W     = 64;
    localparam int ADDR_W    = 16;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int N_CHAN    = 3;
    localparam int PLANE_W   = 3;
    localparam int CFG_IDX_W = 3;

    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 8;
    localparam int OUT_DATA_W = 144;

    localparam logic [SAMPLE_W-1:0]  QMAX     = 16'hFFFF;
    localparam logic [GAIN_W-1:0]    GAIN_ONE = 32'h0001_0000;

    // Register indexes of the configuration port. Gains use indexes 0..5.
    localparam logic [CFG_IDX_W-1:0] REG_GAIN0      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LUMINOSITY = 3'd6;

    // Finished channel: clamped value, excess above full scale, and
    // magnitude below zero.
    typedef struct packed {
        logic [SAMPLE_W-1:0] under;
        logic [SAMPLE_W-1:0] over;
        logic [SAMPLE_W-1:0] val;
    } t_chan_res;

endpackage

// ===== sv/wavelet_plane_recombiner.sv =====
// Top level of the wavelet plane recombiner: accumulator store, weighting
// pipeline and output queue. Depends on wpr_pkg, wpr_ram and wpr_finish.
//
// Wavelet planes stream in one after another, each in raster order. Every
// item is a pixel of one plane; its channels are optionally negated, scaled
// by the Q16.16 gain of its plane and written into, or added with 64-bit
// saturation onto, a per-pixel accumulator held in a 65536-entry RAM. On an
// item flagged final_plane the sum is scaled by the Q16.16 luminosity and
// one result item leaves with clamped value, overflow and underflow per
// channel; frame_end rides on tlast. The block takes one item per clock
// while tready is high. The accumulator RAM is read when an item is
// accepted and written from stage 2; the two newer writes still in
// flight are forwarded, so neighboring items at the same pixel (for
// example one-pixel planes) are handled at full rate. A result passes
// the finishing pipe and queues in an 8-entry buffer, and tready drops
// only while that buffer together with the results still in the pipe
// is full, so a stalled output stops the input once committed results
// fill it, and nothing is lost. The store has no reset: an accumulator
// must be written by a first_plane item before anything adds to or
// reads it, and there is no clearing pass after reset. Configuration
// registers may be written only while the block is idle.
module wavelet_plane_recombiner #(
    parameter int          PLANES       = 6,
    parameter int unsigned FRAME_PIXELS = 65536
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // Configuration: index 0..5 gain of plane 0..5, index 6 luminosity.
    input  logic                                i_cfg_wr_en,
    input  logic [wpr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [wpr_pkg::GAIN_W-1:0]          i_cfg_data,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: in_red[15:0], in_green[31:16], in_blue[47:32]
    input  logic [wpr_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // tuser: plane[2:0], negate_red[3], negate_green[4], negate_blue[5],
    //        first_plane[6], final_plane[7]
    input  logic [wpr_pkg::IN_USER_W-1:0]       s_axis_tuser,
    // tlast: plane_end
    input  logic                                s_axis_tlast,

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: out_red, out_green, out_blue, over_red, over_green, over_blue,
    //        under_red, under_green, under_blue, 16 bits each from bit 0 up
    output logic [wpr_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // tlast: frame_end
    output logic                                m_axis_tlast
);

    localparam int SW = wpr_pkg::SAMPLE_W;
    localparam int AW = wpr_pkg::ADDR_W;
    localparam int CW = wpr_pkg::ACC_W;
    localparam int NC = wpr_pkg::N_CHAN;

    // Position compare width covers both the counter and the frame size.
    localparam int FP_W  = $clog2(FRAME_PIXELS + 1);
    localparam int CMP_W = (FP_W > AW + 1) ? FP_W : AW + 1;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = FIFO_AW + 1;
    localparam int PEND_W     = CNT_W + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [wpr_pkg::GAIN_W-1:0] r_gain [PLANES];
    logic [wpr_pkg::GAIN_W-1:0] r_lum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PLANES; i++) begin
                r_gain[i] <= wpr_pkg::GAIN_ONE;
            end
            r_lum <= wpr_pkg::GAIN_ONE;
        end else if (i_cfg_wr_en) begin
            for (int i = 0; i < PLANES; i++) begin
                if (i_cfg_idx == wpr_pkg::REG_GAIN0 + wpr_pkg::CFG_IDX_W'(i)) begin
                    r_gain[i] <= i_cfg_data;
                end
            end
            if (i_cfg_idx == wpr_pkg::REG_LUMINOSITY) begin
                r_lum <= i_cfg_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input decode, position counter and gain selection
    // ------------------------------------------------------------------
    logic                         accept;
    logic [wpr_pkg::PLANE_W-1:0]  in_plane;
    logic [AW:0]                  pos_inc;
    logic                         wrap;
    logic [AW-1:0]                r_pos;
    logic [AW-1:0]                n_pos;
    logic [wpr_pkg::GAIN_W-1:0]   sel_gain;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign in_plane = s_axis_tuser[wpr_pkg::PLANE_W-1:0];
    assign pos_inc  = {1'b0, r_pos} + 1'b1;
    assign wrap     = s_axis_tlast || (CMP_W'(pos_inc) >= CMP_W'(FRAME_PIXELS));
    assign n_pos    = wrap ? '0 : pos_inc[AW-1:0];

    // Planes beyond the configured count carry a gain of zero.
    always_comb begin
        sel_gain = '0;
        for (int i = 0; i < PLANES; i++) begin
            if (in_plane == wpr_pkg::PLANE_W'(i)) begin
                sel_gain = r_gain[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (accept) begin
            r_pos <= n_pos;
        end
    end

    // ------------------------------------------------------------------
    // Accumulator store: read on accept, written from stage 2
    // ------------------------------------------------------------------
    logic [NC*CW-1:0] ram_rd_data;
    logic [NC*CW-1:0] ram_wr_data;

    // ------------------------------------------------------------------
    // Pipeline registers
    // ------------------------------------------------------------------
    // Stage 1: samples and gain; the store read data arrives here.
    logic                        r_v1, r_fin1, r_first1, r_end1;
    logic [NC-1:0]               r_neg1;
    logic [SW-1:0]               r_samp1 [NC];
    logic [wpr_pkg::GAIN_W-1:0]  r_gain1;
    logic [AW-1:0]               r_addr1;
    // Stage 2: weighted samples and current sums; the new sums are written.
    logic                        r_v2, r_fin2, r_first2, r_end2;
    logic [NC-1:0]               r_neg2;
    logic [wpr_pkg::PROD_W-1:0]  r_prod2 [NC];
    logic [CW-1:0]               r_acc2 [NC];
    logic [AW-1:0]               r_addr2;
    // Stage 3: new sums, kept for forwarding and fed to the finishing pipe.
    logic                        r_v3, r_fin3, r_end3;
    logic [CW-1:0]               r_sum3 [NC];
    logic [AW-1:0]               r_addr3;
    // Stages 4 to 6 carry only results to be emitted.
    logic                        r_v4, r_v5, r_v6;
    logic                        r_end4, r_end5, r_end6;

    logic [wpr_pkg::PROD_W-1:0]  prod [NC];
    logic [CW-1:0]               n_acc2 [NC];
    logic [CW-1:0]               n_sum3 [NC];
    logic                        fwd_s2, fwd_s3;

    // Two older items may still be on their way into the store; the newer
    // one wins.
    assign fwd_s2 = r_v2 && (r_addr2 == r_addr1);
    assign fwd_s3 = r_v3 && (r_addr3 == r_addr1);

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            prod[c] = wpr_pkg::PROD_W'(r_samp1[c]) * wpr_pkg::PROD_W'(r_gain1);
            priority if (fwd_s2) begin
                n_acc2[c] = n_sum3[c];
            end else if (fwd_s3) begin
                n_acc2[c] = r_sum3[c];
            end else begin
                n_acc2[c] = ram_rd_data[c*CW +: CW];
            end
        end
    end

    // Saturating add of the signed weight; negation folds into the adder.
    always_comb begin
        logic [CW-1:0] base;
        logic [CW:0]   addend;
        logic [CW:0]   sum_x;
        for (int c = 0; c < NC; c++) begin
            base   = r_first2 ? '0 : r_acc2[c];
            addend = (CW + 1)'(r_prod2[c]);
            if (r_neg2[c]) begin
                addend = ~addend;
            end
            sum_x = {base[CW-1], base} + addend + (CW + 1)'(r_neg2[c]);
            if (sum_x[CW] != sum_x[CW-1]) begin
                n_sum3[c] = sum_x[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
            end else begin
                n_sum3[c] = sum_x[CW-1:0];
            end
            ram_wr_data[c*CW +: CW] = n_sum3[c];
        end
    end

    wpr_ram #(
        .WIDTH (NC * CW),
        .DEPTH (wpr_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (r_v2),
        .i_wr_addr (r_addr2),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (accept),
        .i_rd_addr (r_pos),
        .o_rd_data (ram_rd_data)
    );

    // Valid bits; the pipe never stalls, so they advance every cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3 && r_fin3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fin1   <= s_axis_tuser[7];
        r_first1 <= s_axis_tuser[6];
        r_neg1   <= s_axis_tuser[5:3];
        r_end1   <= wrap;
        r_gain1  <= sel_gain;
        r_addr1  <= r_pos;
        for (int c = 0; c < NC; c++) begin
            r_samp1[c] <= s_axis_tdata[c*SW +: SW];
        end

        r_fin2   <= r_fin1;
        r_first2 <= r_first1;
        r_neg2   <= r_neg1;
        r_end2   <= r_end1;
        r_addr2  <= r_addr1;
        for (int c = 0; c < NC; c++) begin
            r_prod2[c] <= prod[c];
            r_acc2[c]  <= n_acc2[c];
        end

        r_fin3  <= r_fin2;
        r_end3  <= r_end2;
        r_addr3 <= r_addr2;
        for (int c = 0; c < NC; c++) begin
            r_sum3[c] <= n_sum3[c];
        end

        r_end4 <= r_end3;
        r_end5 <= r_end4;
        r_end6 <= r_end5;
    end

    // ------------------------------------------------------------------
    // Luminosity scale and clamp, one pipe per channel
    // ------------------------------------------------------------------
    wpr_pkg::t_chan_res res [NC];

    for (genvar c = 0; c < NC; c++) begin : g_finish
        wpr_finish u_finish (
            .i_clk (i_clk),
            .i_sum (r_sum3[c]),
            .i_lum (r_lum),
            .o_res (res[c])
        );
    end

    // ------------------------------------------------------------------
    // Output queue
    // ------------------------------------------------------------------
    logic [wpr_pkg::OUT_DATA_W-1:0] r_fifo_data [FIFO_DEPTH];
    logic                           r_fifo_last [FIFO_DEPTH];
    logic [FIFO_AW-1:0]             r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]               r_count;
    logic [wpr_pkg::OUT_DATA_W-1:0] res_data;
    logic                           push, pop;
    logic [PEND_W-1:0]              pending;

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            res_data[c*SW +: SW]            = res[c].val;
            res_data[(c + NC)*SW +: SW]     = res[c].over;
            res_data[(c + 2*NC)*SW +: SW]   = res[c].under;
        end
    end

    assign push = r_v6;
    assign pop  = m_axis_tvalid && m_axis_tready;

    // Results already queued plus every emitting item still in the pipe.
    assign pending = PEND_W'(r_count)
                   + PEND_W'(r_v1 && r_fin1) + PEND_W'(r_v2 && r_fin2)
                   + PEND_W'(r_v3 && r_fin3) + PEND_W'(r_v4)
                   + PEND_W'(r_v5) + PEND_W'(r_v6);

    assign s_axis_tready = (pending <= PEND_W'(FIFO_DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo_data[r_wr_ptr] <= res_data;
            r_fifo_last[r_wr_ptr] <= r_end6;
        end
    end

    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = r_fifo_data[r_rd_ptr];
    assign m_axis_tlast  = r_fifo_last[r_rd_ptr];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_overcommit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pending <= PEND_W'(FIFO_DEPTH))
        else $error("more results committed than the output queue holds");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_count == $past(r_count) + CNT_W'($past(push)) - CNT_W'($past(pop)))
        else $error("output queue count out of step with push and pop");

    a_emit_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_fin1) |-> ##5 r_v6)
        else $error("emitting item did not reach the output queue in time");

    a_plane_end_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && s_axis_tlast) |=> r_pos == '0)
        else $error("position did not return to zero at plane end");

endmodule

// ===== sv/wpr_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// A read at the address being written returns the old contents. No dependencies.
module wpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/wpr_finish.sv =====
// Three-stage finishing pipe for one channel: magnitude, luminosity scale,
// clamp into value, overflow and underflow. Depends on wpr_pkg.
module wpr_finish (
    input  logic                                 i_clk,
    input  logic signed [wpr_pkg::ACC_W-1:0]     i_sum,
    input  logic        [wpr_pkg::GAIN_W-1:0]    i_lum,
    output wpr_pkg::t_chan_res                   o_res
);

    localparam int HALF_W = wpr_pkg::ACC_W / 2;
    localparam logic [wpr_pkg::ACC_W-1:0] Q_MAX_W  = wpr_pkg::ACC_W'(wpr_pkg::QMAX);
    localparam logic [wpr_pkg::ACC_W-1:0] OVER_LIM = Q_MAX_W << 1;

    logic                          r_neg_a;
    logic [wpr_pkg::ACC_W-1:0]     r_mag;
    logic                          r_neg_b;
    logic [wpr_pkg::ACC_W-1:0]     r_lo;
    logic [wpr_pkg::ACC_W-1:0]     r_hi;
    wpr_pkg::t_chan_res            r_res;

    logic [wpr_pkg::ACC_W-1:0]     n_mag;
    logic [wpr_pkg::ACC_W-1:0]     int_part;
    logic [wpr_pkg::ACC_W-1:0]     excess;
    wpr_pkg::t_chan_res            n_res;

    // The most negative sum negates to 2^63, which is still right unsigned.
    assign n_mag = i_sum[wpr_pkg::ACC_W-1] ? (~i_sum + 1'b1) : i_sum;

    // Integer part of magnitude times luminosity, both Q16.16.
    assign int_part = r_hi + {{HALF_W{1'b0}}, r_lo[wpr_pkg::ACC_W-1:HALF_W]};
    assign excess   = int_part - Q_MAX_W;

    always_comb begin
        n_res = '0;
        if (r_neg_b) begin
            n_res.under = (int_part > Q_MAX_W) ? wpr_pkg::QMAX
                                               : int_part[wpr_pkg::SAMPLE_W-1:0];
        end else if (int_part > Q_MAX_W) begin
            n_res.val  = wpr_pkg::QMAX;
            n_res.over = (int_part > OVER_LIM) ? wpr_pkg::QMAX
                                               : excess[wpr_pkg::SAMPLE_W-1:0];
        end else begin
            n_res.val = int_part[wpr_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg_a <= i_sum[wpr_pkg::ACC_W-1];
        r_mag   <= n_mag;
        r_neg_b <= r_neg_a;
        r_lo    <= wpr_pkg::ACC_W'(r_mag[HALF_W-1:0]) * wpr_pkg::ACC_W'(i_lum);
        r_hi    <= wpr_pkg::ACC_W'(r_mag[wpr_pkg::ACC_W-1:HALF_W]) * wpr_pkg::ACC_W'(i_lum);
        r_res   <= n_res;
    end

    assign o_res = r_res;

endmodule

// ===== tb/sv/recombiner_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the wavelet plane recombiner. It watches the register port
// and both streams, predicts every reconstructed pixel and compares it.
// Depends on wpr_pkg.
module recombiner_checker
    import wpr_pkg::*;
#(
    parameter int          PLANES       = 6,
    parameter int unsigned FRAME_PIXELS = 65536
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [GAIN_W-1:0]     i_cfg_data,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    input  logic                  s_axis_tlast,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  m_axis_tlast,
    output int                    o_pending,
    output int                    o_mismatches,
    output int                    o_pixels_checked
);

    localparam int USER_NEG_LO = 3;
    localparam int USER_FIRST  = 6;
    localparam int USER_EMIT   = 7;
    localparam int MAX_PRINTS  = 40;

    typedef struct packed {
        logic                      frame_end;
        t_chan_res [N_CHAN-1:0]    chan;
    } pixel_result_t;

    logic [GAIN_W-1:0] plane_gain [0:5];
    logic [GAIN_W-1:0] lum_scale;
    logic [ADDR_W-1:0] store_addr;
    logic [ACC_W-1:0]  sum_store [0:N_CHAN-1][0:STORE_DEPTH-1];
    pixel_result_t     expected_pixels [$];
    string             chan_name [N_CHAN];
    int                mismatches = 0;
    int                checked = 0;

    initial chan_name = '{"red", "green", "blue"};

    task automatic report_failure(input string msg);
        if (mismatches < MAX_PRINTS) begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
        mismatches++;
    endtask

    // Signed Q16.16 weight of one sample.
    function automatic logic [ACC_W-1:0] scale_sample(input logic [SAMPLE_W-1:0] sample,
                                                      input logic negate,
                                                      input logic [GAIN_W-1:0] gain);
        logic [ACC_W-1:0] prod;
        prod = ACC_W'(sample) * ACC_W'(gain);
        return negate ? -prod : prod;
    endfunction

    function automatic logic [ACC_W-1:0] add_saturating(input logic [ACC_W-1:0] a,
                                                        input logic [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) begin
            return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return s[ACC_W-1:0];
    endfunction

    // Scales a sum by the luminosity, drops the fraction and splits it into
    // the clamped value, the excess above full scale and the underflow.
    function automatic t_chan_res finish_channel(input logic [ACC_W-1:0] acc,
                                                 input logic [GAIN_W-1:0] lum);
        logic [63:0] mag, lo, hi, whole, excess;
        t_chan_res res;
        mag   = acc[ACC_W-1] ? -acc : acc;
        lo    = {32'b0, mag[31:0]} * {32'b0, lum};
        hi    = {32'b0, mag[63:32]} * {32'b0, lum};
        whole = hi + (lo >> 32);
        res   = '0;
        if (acc[ACC_W-1]) begin
            res.under = (whole > 64'(QMAX)) ? QMAX : whole[SAMPLE_W-1:0];
        end else if (whole > 64'(QMAX)) begin
            excess  = whole - 64'(QMAX);
            res.val  = QMAX;
            res.over = (excess > 64'(QMAX)) ? QMAX : excess[SAMPLE_W-1:0];
        end else begin
            res.val = whole[SAMPLE_W-1:0];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        pixel_result_t           got, want;
        logic [PLANE_W-1:0]      plane;
        logic [GAIN_W-1:0]       gain;
        logic [ACC_W-1:0]        weighted;
        logic [ADDR_W:0]         next_addr;
        logic                    wrap;
        if (!i_rst_n) begin
            for (int p = 0; p < 6; p++) begin
                plane_gain[p] = GAIN_ONE;
            end
            lum_scale  = GAIN_ONE;
            store_addr = '0;
            expected_pixels.delete();
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_idx < REG_LUMINOSITY) begin
                    plane_gain[i_cfg_idx] = i_cfg_data;
                end else if (i_cfg_idx == REG_LUMINOSITY) begin
                    lum_scale = i_cfg_data;
                end
            end

            if (m_axis_tvalid && m_axis_tready) begin
                for (int c = 0; c < N_CHAN; c++) begin
                    got.chan[c].val   = m_axis_tdata[SAMPLE_W*c +: SAMPLE_W];
                    got.chan[c].over  = m_axis_tdata[SAMPLE_W*(N_CHAN+c) +: SAMPLE_W];
                    got.chan[c].under = m_axis_tdata[SAMPLE_W*(2*N_CHAN+c) +: SAMPLE_W];
                end
                got.frame_end = m_axis_tlast;
                if (expected_pixels.size() == 0) begin
                    report_failure($sformatf("result with no pixel expected, tdata %h",
                                             m_axis_tdata));
                end else begin
                    want = expected_pixels.pop_front();
                    checked++;
                    for (int c = 0; c < N_CHAN; c++) begin
                        if (got.chan[c].val !== want.chan[c].val)
                            report_failure($sformatf("pixel %0d out_%s %0d, expected %0d",
                                checked, chan_name[c], got.chan[c].val, want.chan[c].val));
                        if (got.chan[c].over !== want.chan[c].over)
                            report_failure($sformatf("pixel %0d over_%s %0d, expected %0d",
                                checked, chan_name[c], got.chan[c].over, want.chan[c].over));
                        if (got.chan[c].under !== want.chan[c].under)
                            report_failure($sformatf("pixel %0d under_%s %0d, expected %0d",
                                checked, chan_name[c], got.chan[c].under,
                                want.chan[c].under));
                    end
                    if (got.frame_end !== want.frame_end)
                        report_failure($sformatf("pixel %0d frame_end %b, expected %b",
                                                 checked, got.frame_end, want.frame_end));
                end
            end

            if (s_axis_tvalid && s_axis_tready) begin
                plane = s_axis_tuser[PLANE_W-1:0];
                gain  = (plane < PLANES && plane < 6) ? plane_gain[plane] : '0;
                for (int c = 0; c < N_CHAN; c++) begin
                    weighted = scale_sample(s_axis_tdata[SAMPLE_W*c +: SAMPLE_W],
                                            s_axis_tuser[USER_NEG_LO+c], gain);
                    sum_store[c][store_addr] = s_axis_tuser[USER_FIRST] ? weighted :
                        add_saturating(sum_store[c][store_addr], weighted);
                end
                next_addr = {1'b0, store_addr} + 1'b1;
                wrap      = s_axis_tlast || (next_addr >= FRAME_PIXELS);
                if (s_axis_tuser[USER_EMIT]) begin
                    for (int c = 0; c < N_CHAN; c++) begin
                        want.chan[c] = finish_channel(sum_store[c][store_addr], lum_scale);
                    end
                    want.frame_end = wrap;
                    expected_pixels = {expected_pixels, want};
                end
                store_addr = wrap ? '0 : next_addr[ADDR_W-1:0];
            end
        end
        o_pending        <= expected_pixels.size();
        o_mismatches     <= mismatches;
        o_pixels_checked <= checked;
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Top of the wavelet plane recombiner testbench: clock, reset, pixel stimulus,
// output back-pressure and the verdict. Depends on wpr_pkg, the block and
// recombiner_checker, which does all prediction and comparison.
module testbench;
    import wpr_pkg::*;

    localparam int          PLANE_COUNT   = 6;
    localparam int unsigned FRAME_SIZE    = 65536;
    localparam int          RANDOM_ITEMS  = 1700;
    // The last stretch of the random part runs with both sides always ready.
    localparam int          CALM_TAIL     = 300;
    localparam int          CONFIG_EVERY  = 250;
    // Extra wait after the last result, to cover the accumulator write
    // that trails an item without a result.
    localparam int          SETTLE_CYCLES = 12;
    localparam longint      CLK_PERIOD    = 12;
    localparam longint      LIMIT_CYCLES  = 2_000_000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [GAIN_W-1:0]     i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [IN_USER_W-1:0]  s_axis_tuser;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    int pending;
    int mismatches;
    int pixels_checked;

    // Stimulus-side bookkeeping: the write position the block should be at
    // and which accumulators hold a value, so that no item ever adds to or
    // reads an accumulator that was never written.
    bit store_written [0:STORE_DEPTH-1];
    int pixel_pos = 0;
    int items_sent = 0;
    int random_sent = 0;
    int config_rounds = 0;
    bit idle_on = 1'b0;

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    wavelet_plane_recombiner #(
        .PLANES       (PLANE_COUNT),
        .FRAME_PIXELS (FRAME_SIZE)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    recombiner_checker #(
        .PLANES       (PLANE_COUNT),
        .FRAME_PIXELS (FRAME_SIZE)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .s_axis_tuser     (s_axis_tuser),
        .s_axis_tlast     (s_axis_tlast),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .m_axis_tlast     (m_axis_tlast),
        .o_pending        (pending),
        .o_mismatches     (mismatches),
        .o_pixels_checked (pixels_checked)
    );

    // Hard stop in case the block hangs or drops a result.
    initial begin : watchdog
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Timed out with %0d results outstanding.", pending);
        $display("RESULT: ERROR");
        $finish;
    end

    // Output back-pressure: while idling is enabled, tready now and then
    // drops for a random burst; otherwise it stays high.
    initial begin : result_sink
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 11) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // Samples lean toward zero, full scale and small values so that exact
    // sums, clamps and fraction truncation all show up often.
    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return QMAX;
            2:       return SAMPLE_W'($urandom_range(0, 255));
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] random_gain();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return GAIN_ONE;
            3:       return GAIN_W'($urandom);
            default: return GAIN_W'($urandom_range(0, 32'h0003_0000));
        endcase
    endfunction

    // Sends one item and returns at the falling edge after it was taken.
    // The caller is always at a falling edge with nothing driven yet, so
    // tvalid gets at most one assignment per time step.
    task automatic push_pixel(input logic [PLANE_W-1:0]  plane,
                              input logic [SAMPLE_W-1:0] red,
                              input logic [SAMPLE_W-1:0] green,
                              input logic [SAMPLE_W-1:0] blue,
                              input logic [N_CHAN-1:0]   negate,
                              input logic                is_first,
                              input logic                emit,
                              input logic                is_last);
        int gap;
        // Adding onto an accumulator that holds nothing is not allowed.
        if (!is_first && !store_written[pixel_pos]) is_first = 1'b1;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 15);
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {blue, green, red};
        s_axis_tuser  <= {emit, is_first, negate, plane};
        s_axis_tlast  <= is_last;
        do @(posedge i_clk); while (!s_axis_tready);
        if (is_first) store_written[pixel_pos] = 1'b1;
        pixel_pos = (is_last || pixel_pos + 1 >= FRAME_SIZE) ? 0 : pixel_pos + 1;
        items_sent++;
        @(negedge i_clk);
    endtask

    // Stops sending and waits until every expected result has come and
    // the last accumulator write has settled.
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // One register write; the write enable goes low again before the next
    // write can raise it.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [GAIN_W-1:0]    value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic program_random_config();
        for (int r = REG_GAIN0; r <= REG_LUMINOSITY; r++) begin
            write_register(CFG_IDX_W'(r), random_gain());
        end
        config_rounds++;
    endtask

    // A well-formed frame: every plane covers the same pixels, the first
    // plane overwrites, the last one emits, plane_end closes each plane.
    // Now and then a plane carries an unexpected index.
    task automatic send_frame();
        int n_pix;
        int n_planes;
        int plane_idx;
        n_pix    = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
        n_planes = $urandom_range(1, PLANE_COUNT);
        for (int k = 0; k < n_planes; k++) begin
            plane_idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : k;
            for (int x = 0; x < n_pix; x++) begin
                push_pixel(PLANE_W'(plane_idx), random_sample(), random_sample(),
                           random_sample(), N_CHAN'($urandom), k == 0,
                           k == n_planes - 1, x == n_pix - 1);
            end
        end
    endtask

    // A short run of items with every flag random, which breaks up the
    // frame structure and shifts the write position.
    task automatic send_noise();
        int n_items;
        n_items = $urandom_range(1, 6);
        repeat (n_items) begin
            push_pixel(PLANE_W'($urandom), random_sample(), random_sample(),
                       random_sample(), N_CHAN'($urandom), $urandom_range(0, 3) == 0,
                       $urandom_range(0, 1) == 1, $urandom_range(0, 4) == 0);
        end
    endtask

    initial begin : stimulus
        int random_start;
        int since_config;

        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_idx     = REG_GAIN0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part at the reset gains: zero, full scale, all channels
        // negated, planes six and seven (no gain) both adding and
        // overwriting, a two-pixel two-plane frame and a six-plane frame.
        idle_on = 1'b1;
        push_pixel(0, 16'h0000, 16'h0000, 16'h0000, 3'b000, 1, 1, 1);
        push_pixel(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b000, 1, 1, 1);
        push_pixel(0, 16'hFFFF, 16'h8000, 16'h0001, 3'b111, 1, 1, 1);
        push_pixel(6, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b000, 0, 1, 1);
        push_pixel(7, 16'h1234, 16'h5678, 16'h9ABC, 3'b101, 1, 1, 1);
        push_pixel(0, 16'h1000, 16'h2000, 16'h3000, 3'b000, 1, 0, 0);
        push_pixel(0, 16'hFFFF, 16'h0000, 16'h8000, 3'b010, 1, 0, 1);
        push_pixel(1, 16'h0800, 16'h3000, 16'h0001, 3'b001, 0, 1, 0);
        push_pixel(1, 16'h0001, 16'hFFFF, 16'h7FFF, 3'b110, 0, 1, 1);
        for (int k = 0; k < PLANE_COUNT; k++) begin
            push_pixel(PLANE_W'(k), SAMPLE_W'(16'h1111 * (k + 1)), SAMPLE_W'(16'h0F0F << k),
                       SAMPLE_W'(16'hFFFF >> k), N_CHAN'(k), k == 0, k == PLANE_COUNT - 1, 1);
        end

        // Extreme gains and luminosity: overflow and underflow clamp at full
        // scale, a zero gain empties the pixel.
        drain_block();
        write_register(REG_GAIN0, '1);
        write_register(REG_GAIN0 + 3'd1, '0);
        write_register(REG_LUMINOSITY, '1);
        push_pixel(0, 16'hFFFF, 16'h0001, 16'h0000, 3'b000, 1, 1, 1);
        push_pixel(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b111, 1, 1, 1);
        push_pixel(1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b000, 1, 1, 1);
        drain_block();
        write_register(REG_LUMINOSITY, '0);
        push_pixel(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b010, 1, 1, 1);

        // A gain of one half leaves fractions; they are dropped toward zero
        // on both signs.
        drain_block();
        write_register(REG_LUMINOSITY, GAIN_ONE);
        write_register(REG_GAIN0 + 3'd2, 32'h0000_8000);
        push_pixel(2, 16'h0003, 16'h0001, 16'hFFFF, 3'b101, 1, 1, 1);

        // Random part: mostly well-formed frames, some noise, with fresh
        // register settings every few hundred items.
        drain_block();
        program_random_config();
        random_start = items_sent;
        since_config = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            if (items_sent - since_config >= CONFIG_EVERY) begin
                drain_block();
                program_random_config();
                since_config = items_sent;
            end
            idle_on = (items_sent - random_start < RANDOM_ITEMS - CALM_TAIL) &&
                      ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 99) < 85) begin
                send_frame();
            end else begin
                send_noise();
            end
        end
        random_sent = items_sent - random_start;

        drain_block();
        $display("Sent %0d pixel items (%0d random) and compared %0d reconstructed pixels.",
                 items_sent, random_sent, pixels_checked);
        $display("Covered field extremes, sign flags, gainless planes, truncation and %0d %s",
                 config_rounds + 4, "register settings.");
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
